[src/vtv_pkg.sv]
// ----------------------------------------------------------------------------
// vtv_pkg: shared types and constants of the vertex transform block
// Request structs, configuration and mode codes, pipeline depths, saturation.
// ----------------------------------------------------------------------------
package vtv_pkg;

    localparam int DATA_W        = 32;
    localparam int CFG_W         = 14;
    localparam int COEF_N        = 32;
    localparam int NRM_BASE      = 16;
    localparam int MAT_LAT       = 2;
    localparam int SQRT_STAGES   = 16;
    localparam int DIV_STAGES    = 16;
    localparam int DIV_LAT       = DIV_STAGES + 2;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_XFORM = 1'b1;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                     mode;
        logic [4:0]               coef_index;
        logic signed [DATA_W-1:0] coef_value;
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
        logic signed [DATA_W-1:0] pos_w;
        logic signed [DATA_W-1:0] nrm_x;
        logic signed [DATA_W-1:0] nrm_y;
        logic signed [DATA_W-1:0] nrm_z;
    } t_in_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] ndc_x;
        logic signed [DATA_W-1:0] ndc_y;
        logic signed [DATA_W-1:0] ndc_z;
        logic signed [DATA_W-1:0] ndc_w;
        logic signed [DATA_W-1:0] screen_x;
        logic signed [DATA_W-1:0] screen_y;
        logic signed [DATA_W-1:0] out_nx;
        logic signed [DATA_W-1:0] out_ny;
        logic signed [DATA_W-1:0] out_nz;
    } t_out_req;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] res;
        if (!v[63] && (|v[62:31])) begin
            res = SAT_MAX;
        end else if (v[63] && !(&v[62:31])) begin
            res = SAT_MIN;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

[src/vtv_mat.sv]
// ----------------------------------------------------------------------------
// vtv_mat: matrix products
// Stage one forms the floored 32x32 products, stage two sums and saturates.
// ----------------------------------------------------------------------------
module vtv_mat import vtv_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [DATA_W-1:0] i_coef [COEF_N],
    input  logic signed [DATA_W-1:0] i_pos  [4],
    input  logic signed [DATA_W-1:0] i_nrm  [3],
    output logic signed [DATA_W-1:0] o_clip [4],
    output logic signed [DATA_W-1:0] o_tn   [3]
);

    logic signed [63:0] r_pp [16];
    logic signed [63:0] r_np [9];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_pp[r*4+c] <= (64'(i_coef[r*4+c]) * 64'(i_pos[c])) >>> FRAC_BITS;
                end
            end
            // w of the normal is zero: fourth column drops out
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_np[r*3+c] <= (64'(i_coef[NRM_BASE+r*4+c]) * 64'(i_nrm[c]))
                                   >>> FRAC_BITS;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                o_clip[r] <= sat32(r_pp[r*4] + r_pp[r*4+1] + r_pp[r*4+2] + r_pp[r*4+3]);
            end
            for (int r = 0; r < 3; r++) begin
                o_tn[r] <= sat32(r_np[r*3] + r_np[r*3+1] + r_np[r*3+2]);
            end
        end
    end

endmodule

[src/vtv_sqrt.sv]
// ----------------------------------------------------------------------------
// vtv_sqrt: pipelined integer square root
// Floor square root of a 64-bit value, two result bits per stage.
// ----------------------------------------------------------------------------
module vtv_sqrt import vtv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_sq,
    output logic [31:0] o_root
);

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] val;
    } t_sq_st;

    t_sq_st r_st [SQRT_STAGES];

    function automatic t_sq_st sq_step(input t_sq_st a);
        t_sq_st      b;
        logic [35:0] rs;
        logic [35:0] tr;
        rs = {a.rem, a.val[63:62]};
        tr = {2'b00, a.root, 2'b01};
        b.val = {a.val[61:0], 2'b00};
        if (rs >= tr) begin
            b.rem  = 34'(rs - tr);
            b.root = {a.root[30:0], 1'b1};
        end else begin
            b.rem  = rs[33:0];
            b.root = {a.root[30:0], 1'b0};
        end
        return b;
    endfunction

    t_sq_st w_init;
    assign w_init = '{rem: '0, root: '0, val: i_sq};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= sq_step(sq_step(w_init));
            for (int s = 1; s < SQRT_STAGES; s++) begin
                r_st[s] <= sq_step(sq_step(r_st[s-1]));
            end
        end
    end

    assign o_root = r_st[SQRT_STAGES-1].root;

endmodule

[src/vtv_div.sv]
// ----------------------------------------------------------------------------
// vtv_div: pipelined fixed-point divider
// (num << FRAC_BITS) / den, truncated toward zero and saturated to 32 bits.
// Two quotient bits per stage; the high part is checked for overflow first.
// ----------------------------------------------------------------------------
module vtv_div import vtv_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [DATA_W-1:0] i_num,
    input  logic signed [DATA_W:0]   i_den,
    output logic signed [DATA_W-1:0] o_quo
);

    localparam int NW = DATA_W + FRAC_BITS;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] lo;
        logic [31:0] quo;
        logic [32:0] dmag;
        logic        neg;
        logic        ovf;
    } t_dv_st;

    function automatic t_dv_st dv_step(input t_dv_st a);
        t_dv_st      b;
        logic [33:0] rs;
        b  = a;
        rs = {a.rem, a.lo[31]};
        b.lo = {a.lo[30:0], 1'b0};
        if (rs >= {1'b0, a.dmag}) begin
            b.rem = 33'(rs - {1'b0, a.dmag});
            b.quo = {a.quo[30:0], 1'b1};
        end else begin
            b.rem = rs[32:0];
            b.quo = {a.quo[30:0], 1'b0};
        end
        return b;
    endfunction

    logic [31:0]   w_nmag;
    logic [NW-1:0] w_nsh;
    logic [32:0]   w_dmag;
    t_dv_st        r_pre;
    t_dv_st        r_st [DIV_STAGES];
    t_dv_st        w_last;

    assign w_nmag = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign w_nsh  = NW'(w_nmag) << FRAC_BITS;
    assign w_dmag = i_den[32] ? 33'(-i_den) : 33'(i_den);
    assign w_last = r_st[DIV_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre.rem  <= 33'(w_nsh[NW-1:32]);
            r_pre.lo   <= w_nsh[31:0];
            r_pre.quo  <= '0;
            r_pre.dmag <= w_dmag;
            r_pre.neg  <= i_num[31] ^ i_den[32];
            r_pre.ovf  <= 33'(w_nsh[NW-1:32]) >= w_dmag;
            r_st[0]    <= dv_step(dv_step(r_pre));
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_st[s] <= dv_step(dv_step(r_st[s-1]));
            end
            if (!w_last.neg) begin
                o_quo <= (w_last.ovf || w_last.quo[31]) ? SAT_MAX : $signed(w_last.quo);
            end else begin
                o_quo <= (w_last.ovf || (w_last.quo > 32'h8000_0000)) ? SAT_MIN
                         : $signed(32'(-w_last.quo));
            end
        end
    end

endmodule

[src/vertex_transform_viewport.sv]
// ----------------------------------------------------------------------------
// vertex_transform_viewport: vertex transform, perspective divide, viewport
// Input channel i_valid/o_stall carries t_in_req. A load request (mode 0)
// writes one matrix coefficient and gives no result; a transform request
// (mode 1) gives one t_out_req on o_valid/i_stall.
// Configuration: i_cfg_we writes i_cfg_data to width (index 0) or height
// (index 1); write only while the block is idle.
// Throughput: one request per cycle while the output is not stalled.
// Pipeline: the matrix stages (2), squares and sum (2), the square root
// (16 stages) and the dividers (18 stages), then the viewport multiply.
// A coefficient load takes effect for the next request.
// Reset clears all valid bits, loads identity into both matrices and sets
// the viewport to 640 x 480.
// While o_valid is high and i_stall is high the whole pipeline holds and
// o_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module vertex_transform_viewport import vtv_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in_req          i_req,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_req         o_req
);

    localparam int ST_IN    = 1;
    localparam int ST_CLIP  = ST_IN + MAT_LAT;
    localparam int ST_SUM   = ST_CLIP + 2;
    localparam int ST_LEN   = ST_SUM + SQRT_STAGES;
    localparam int ST_QUO   = ST_LEN + DIV_LAT;
    localparam int ST_OUT   = ST_QUO + 3;
    localparam int CLIP_DLY = ST_QUO - ST_CLIP;
    localparam int TN_DLY   = ST_LEN - ST_CLIP;
    localparam logic signed [DATA_W:0] ONE = 33'(1) << FRAC_BITS;

    logic                     w_en;
    logic [ST_OUT:ST_IN]      r_vld;
    logic [CFG_W-1:0]         r_width;
    logic [CFG_W-1:0]         r_height;
    logic signed [DATA_W-1:0] r_coef  [COEF_N];
    t_in_req                  r_in;
    logic signed [DATA_W-1:0] w_pos   [4];
    logic signed [DATA_W-1:0] w_nrm   [3];
    logic signed [DATA_W-1:0] w_clip  [4];
    logic signed [DATA_W-1:0] w_tn    [3];
    logic signed [63:0]       r_sq    [3];
    logic [63:0]              r_sqsum;
    logic [31:0]              w_len;
    logic signed [DATA_W-1:0] r_clip_d [CLIP_DLY][4];
    logic signed [DATA_W-1:0] r_tn_d   [TN_DLY][3];
    logic                     r_lz_d   [DIV_LAT];
    logic signed [DATA_W-1:0] w_dq    [3];
    logic signed [DATA_W-1:0] w_nq    [3];
    logic signed [DATA_W-1:0] r_ndc   [4];
    logic signed [DATA_W-1:0] r_nrm   [3];
    logic signed [DATA_W-1:0] r_ndc2  [4];
    logic signed [DATA_W-1:0] r_nrm2  [3];
    logic signed [47:0]       r_scr_p [2];
    logic                     w_wz;

    assign w_en    = !(r_vld[ST_OUT] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[ST_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(640);
            r_height <= CFG_W'(480);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    r_width  <= r_width;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < COEF_N; k++) begin
                r_coef[k] <= ((k % 16) % 5 == 0) ? $signed(32'(1) << FRAC_BITS) : '0;
            end
        end else if (i_valid && w_en && (i_req.mode == MODE_LOAD)) begin
            r_coef[i_req.coef_index] <= i_req.coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[ST_OUT-1:ST_IN], i_valid && (i_req.mode == MODE_XFORM)};
        end
    end

    assign w_pos[0] = r_in.pos_x;
    assign w_pos[1] = r_in.pos_y;
    assign w_pos[2] = r_in.pos_z;
    assign w_pos[3] = r_in.pos_w;
    assign w_nrm[0] = r_in.nrm_x;
    assign w_nrm[1] = r_in.nrm_y;
    assign w_nrm[2] = r_in.nrm_z;

    vtv_mat #(.FRAC_BITS(FRAC_BITS)) u_mat (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_coef (r_coef),
        .i_pos  (w_pos),
        .i_nrm  (w_nrm),
        .o_clip (w_clip),
        .o_tn   (w_tn)
    );

    vtv_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_sq   (r_sqsum),
        .o_root (w_len)
    );

    for (genvar g = 0; g < 3; g++) begin : g_div
        vtv_div #(.FRAC_BITS(FRAC_BITS)) u_pdiv (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_clip_d[TN_DLY-1][g]),
            .i_den (33'($signed(r_clip_d[TN_DLY-1][3]))),
            .o_quo (w_dq[g])
        );
        vtv_div #(.FRAC_BITS(FRAC_BITS)) u_ndiv (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_tn_d[TN_DLY-1][g]),
            .i_den ($signed({1'b0, w_len})),
            .o_quo (w_nq[g])
        );
    end

    assign w_wz = (r_clip_d[CLIP_DLY-1][3] == '0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in <= i_req;
            for (int c = 0; c < 3; c++) begin
                r_sq[c] <= 64'(w_tn[c]) * 64'(w_tn[c]);
            end
            r_sqsum <= r_sq[0] + r_sq[1] + r_sq[2];
            r_clip_d[0] <= w_clip;
            r_tn_d[0]   <= w_tn;
            for (int k = 1; k < CLIP_DLY; k++) begin
                r_clip_d[k] <= r_clip_d[k-1];
            end
            for (int k = 1; k < TN_DLY; k++) begin
                r_tn_d[k] <= r_tn_d[k-1];
            end
            r_lz_d[0] <= (w_len == '0);
            for (int k = 1; k < DIV_LAT; k++) begin
                r_lz_d[k] <= r_lz_d[k-1];
            end
            // zero clip w: pass clip values through
            for (int c = 0; c < 3; c++) begin
                r_ndc[c] <= w_wz ? r_clip_d[CLIP_DLY-1][c] : w_dq[c];
                r_nrm[c] <= r_lz_d[DIV_LAT-1] ? '0 : w_nq[c];
            end
            r_ndc[3] <= w_wz ? '0 : 32'(ONE);
            r_ndc2   <= r_ndc;
            r_nrm2   <= r_nrm;
            r_scr_p[0] <= 48'(33'($signed(r_ndc[0])) + ONE) * 48'($signed({1'b0, r_width}));
            r_scr_p[1] <= 48'(33'($signed(r_ndc[1])) + ONE) * 48'($signed({1'b0, r_height}));
            o_req.ndc_x    <= r_ndc2[0];
            o_req.ndc_y    <= r_ndc2[1];
            o_req.ndc_z    <= r_ndc2[2];
            o_req.ndc_w    <= r_ndc2[3];
            o_req.screen_x <= sat32(64'(r_scr_p[0] >>> 1));
            o_req.screen_y <= sat32(64'(r_scr_p[1] >>> 1));
            o_req.out_nx   <= r_nrm2[0];
            o_req.out_ny   <= r_nrm2[1];
            o_req.out_nz   <= r_nrm2[2];
        end
    end

endmodule

[src/vtv_chk.sv]
// ----------------------------------------------------------------------------
// vtv_chk: port-level checks of the vertex transform block
// Output hold under stall, stall source, reset behavior, ndc_w encoding.
// ----------------------------------------------------------------------------
module vtv_chk import vtv_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input t_out_req         o_req
);

    localparam logic signed [DATA_W-1:0] ONE_Q = 32'(1) << FRAC_BITS;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_req)))
        else $error("result changed while stalled");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output stall");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result after reset");

    a_ndc_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_req.ndc_w != '0)) |-> (o_req.ndc_w == ONE_Q))
        else $error("ndc_w neither zero nor one");

endmodule

bind vertex_transform_viewport vtv_chk #(.FRAC_BITS(FRAC_BITS)) u_vtv_chk (.*);

[test/tb_vertex_transform_viewport.sv]
// ----------------------------------------------------------------------------
// tb_vertex_transform_viewport: self-checking bench of the vertex transform
// A queue of requests feeds a driver; a monitor compares every result with a
// fixed-point transform predictor, under random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_vertex_transform_viewport;
    import vtv_pkg::*;

    localparam int FRAC     = 16;
    localparam int LAT      = 42;
    localparam int CYC_MAX  = 400000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_idx = CFG_WIDTH;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    t_in_req          i_req = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    t_out_req         o_req;

    vertex_transform_viewport u_dut (.*);

    always #5 i_clk = ~i_clk;

    t_in_req  pending_q[$];
    t_out_req vertex_q[$];
    logic signed [31:0] coef_m[32];
    logic [13:0] view_w, view_h;
    int errors = 0;
    int cycles = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    logic hold_src = 1'b0;
    logic in_taken = 1'b0;

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint q_div(longint num, longint den);
        longint n;
        n = num <<< FRAC;
        return clamp32(n / den);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // a load updates the coefficient store and returns 0; a transform returns 1 with the expected vertex
    function automatic bit transform_vertex(t_in_req rq, output t_out_req vx);
        longint pos[4], nrm[4], clip[4], ndc[4], tn[3], acc, one;
        logic [63:0] sq, len;
        one = longint'(1) <<< FRAC;
        vx = '0;
        if (rq.mode == MODE_LOAD) begin
            coef_m[rq.coef_index] = rq.coef_value;
            return 1'b0;
        end
        pos[0] = longint'(rq.pos_x); pos[1] = longint'(rq.pos_y);
        pos[2] = longint'(rq.pos_z); pos[3] = longint'(rq.pos_w);
        nrm[0] = longint'(rq.nrm_x); nrm[1] = longint'(rq.nrm_y);
        nrm[2] = longint'(rq.nrm_z); nrm[3] = 0;
        for (int r = 0; r < 4; r++) begin
            acc = 0;
            for (int c = 0; c < 4; c++) acc += floor_sh(longint'(coef_m[r*4+c]) * pos[c], FRAC);
            clip[r] = clamp32(acc);
        end
        if (clip[3] != 0) begin
            for (int c = 0; c < 3; c++) ndc[c] = q_div(clip[c], clip[3]);
            ndc[3] = one;
        end else begin
            for (int c = 0; c < 4; c++) ndc[c] = clip[c];
        end
        sq = 0;
        for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int c = 0; c < 4; c++)
                acc += floor_sh(longint'(coef_m[NRM_BASE+r*4+c]) * nrm[c], FRAC);
            tn[r] = clamp32(acc);
            sq += 64'(tn[r] * tn[r]);
        end
        len = int_sqrt(sq);
        vx.ndc_x = 32'(ndc[0]); vx.ndc_y = 32'(ndc[1]);
        vx.ndc_z = 32'(ndc[2]); vx.ndc_w = 32'(ndc[3]);
        vx.screen_x = 32'(clamp32(floor_sh((ndc[0] + one) * longint'(view_w), 1)));
        vx.screen_y = 32'(clamp32(floor_sh((ndc[1] + one) * longint'(view_h), 1)));
        if (len != 0) begin
            vx.out_nx = 32'(q_div(tn[0], longint'(len)));
            vx.out_ny = 32'(q_div(tn[1], longint'(len)));
            vx.out_nz = 32'(q_div(tn[2], longint'(len)));
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
        errors++;
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (pending_q.size() > 0 && !hold_src && $urandom_range(99) >= src_idle_pct) begin
                i_req <= pending_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= ($urandom_range(99) < snk_idle_pct);
    end

    always @(posedge i_clk) begin
        t_out_req vx;
        cycles++;
        if (cycles > CYC_MAX) begin
            $display("FAIL vertex_transform_viewport");
            $finish;
        end
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            if (transform_vertex(i_req, vx)) vertex_q.push_back(vx);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (vertex_q.size() == 0) begin
                report_mismatch("unexpected", '0, '0);
            end else begin
                vx = vertex_q.pop_front();
                if (o_req.ndc_x !== vx.ndc_x) report_mismatch("ndc_x", o_req.ndc_x, vx.ndc_x);
                if (o_req.ndc_y !== vx.ndc_y) report_mismatch("ndc_y", o_req.ndc_y, vx.ndc_y);
                if (o_req.ndc_z !== vx.ndc_z) report_mismatch("ndc_z", o_req.ndc_z, vx.ndc_z);
                if (o_req.ndc_w !== vx.ndc_w) report_mismatch("ndc_w", o_req.ndc_w, vx.ndc_w);
                if (o_req.screen_x !== vx.screen_x)
                    report_mismatch("screen_x", o_req.screen_x, vx.screen_x);
                if (o_req.screen_y !== vx.screen_y)
                    report_mismatch("screen_y", o_req.screen_y, vx.screen_y);
                if (o_req.out_nx !== vx.out_nx) report_mismatch("out_nx", o_req.out_nx, vx.out_nx);
                if (o_req.out_ny !== vx.out_ny) report_mismatch("out_ny", o_req.out_ny, vx.out_ny);
                if (o_req.out_nz !== vx.out_nz) report_mismatch("out_nz", o_req.out_nz, vx.out_nz);
            end
        end
    end

    function automatic logic [31:0] rand_q(int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
            2: return 32'($signed($urandom_range(65536)) - 32768);
            default: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    default: return 32'h0001_0000;
                endcase
            end
        endcase
    endfunction

    function automatic t_in_req load_req(int idx, logic [31:0] v);
        t_in_req rq;
        rq = '0;
        rq.mode = MODE_LOAD;
        rq.coef_index = 5'(idx);
        rq.coef_value = v;
        rq.pos_x = $urandom();
        rq.nrm_z = $urandom();
        return rq;
    endfunction

    function automatic t_in_req xform_req(int kind);
        t_in_req rq;
        rq = '0;
        rq.mode = MODE_XFORM;
        rq.coef_index = 5'($urandom());
        rq.coef_value = $urandom();
        rq.pos_x = rand_q(kind); rq.pos_y = rand_q(kind);
        rq.pos_z = rand_q(kind); rq.pos_w = rand_q(kind);
        rq.nrm_x = rand_q(kind); rq.nrm_y = rand_q(kind); rq.nrm_z = rand_q(kind);
        return rq;
    endfunction

    task automatic drain();
        while (pending_q.size() > 0 || i_valid || vertex_q.size() > 0) @(posedge i_clk);
        repeat (LAT + 8) @(posedge i_clk);
    endtask

    task automatic set_view(logic [13:0] w, logic [13:0] h);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= CFG_WIDTH; i_cfg_data <= w;
        @(negedge i_clk);
        i_cfg_idx <= CFG_HEIGHT; i_cfg_data <= h;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        view_w = w; view_h = h;
    endtask

    initial begin
        t_in_req rq;
        logic [13:0] sizes_w[5] = '{14'd640, 14'd1, 14'd8192, 14'd16383, 14'd0};
        logic [13:0] sizes_h[5] = '{14'd480, 14'd8192, 14'd1, 14'd0, 14'd16383};
        for (int i = 0; i < 32; i++) coef_m[i] = ((i & 15) % 5 == 0) ? 32'h0001_0000 : 32'h0;
        view_w = 14'd640; view_h = 14'd480;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset matrices, extremes, zero w, zero normal, loads
        rq = xform_req(0);
        rq.pos_x = 32'h0000_8000; rq.pos_y = 32'hFFFF_8000; rq.pos_z = 0; rq.pos_w = 32'h0001_0000;
        rq.nrm_x = 32'h0003_0000; rq.nrm_y = 32'h0004_0000; rq.nrm_z = 0;
        pending_q.push_back(rq);
        rq.pos_w = 0; rq.nrm_x = 0; rq.nrm_y = 0; pending_q.push_back(rq);
        rq.pos_x = 32'h7FFF_FFFF; rq.pos_y = 32'h8000_0000; rq.pos_z = 32'h7FFF_FFFF;
        rq.pos_w = 32'h0000_0001; rq.nrm_x = 32'h7FFF_FFFF; rq.nrm_y = 32'h8000_0000;
        rq.nrm_z = 32'h7FFF_FFFF; pending_q.push_back(rq);
        rq.pos_w = 32'hFFFF_FFFF; pending_q.push_back(rq);
        pending_q.push_back(xform_req(3));
        pending_q.push_back(load_req(15, 32'h8000_0000));
        pending_q.push_back(load_req(16, 32'h7FFF_FFFF));
        pending_q.push_back(load_req(3, 32'h0002_0000));
        pending_q.push_back(load_req(31, 32'hFFFF_0000));
        pending_q.push_back(xform_req(2));
        pending_q.push_back(xform_req(0));
        pending_q.push_back(xform_req(3));

        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                drain();
                set_view(sizes_w[ph], sizes_h[ph]);
            end
            src_idle_pct = (ph < 2) ? 20 : (ph < 4) ? 46 : 0;
            snk_idle_pct = (ph < 2) ? 46 : (ph < 4) ? 20 : 0;
            for (int n = 0; n < 230; n++) begin
                if ($urandom_range(9) == 0) begin
                    for (int k = 0; k < 4; k++)
                        pending_q.push_back(load_req($urandom_range(31), rand_q($urandom_range(3))));
                end else begin
                    pending_q.push_back(xform_req($urandom_range(3)));
                end
            end
            if (ph == 2) begin
                while (pending_q.size() > 150) @(posedge i_clk);
                hold_src = 1'b1;
                while (vertex_q.size() > 0) @(posedge i_clk);
                hold_src = 1'b0;
            end
        end
        drain();
        if (errors == 0) begin
            $display("PASS vertex_transform_viewport");
        end else begin
            $display("FAIL vertex_transform_viewport");
        end
        $finish;
    end

endmodule
